FILE: src/cpt_pkg.sv
// Shared constants and types for the closest-point-on-triangle pipeline.
package cpt_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int WEIGHT_BITS = 16;

  typedef enum logic [2:0] {
    RGN_CORNER_A = 3'd0,
    RGN_CORNER_B = 3'd1,
    RGN_EDGE_AB  = 3'd2,
    RGN_CORNER_C = 3'd3,
    RGN_EDGE_AC  = 3'd4,
    RGN_EDGE_BC  = 3'd5,
    RGN_INTERIOR = 3'd6
  } region_e;

endpackage

FILE: src/closest_point_on_triangle_top.sv
// Closest point on a triangle: one request per cycle unless stalled; WEIGHT_BITS + 11 register stages.
// Throughput: one request per cycle unless stalled; weight divider unrolled, one quotient bit a stage.
// Stalls: every stage holds while the stage after it is full and held; bubbles collapse.
// Reset: rst_ni clears all stage valid bits; payload registers are not reset.
module closest_point_on_triangle_top #(
  parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // query_x, query_y, query_z, corner_a_x..z, corner_b_x..z, corner_c_x..z
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // near_x, near_y, near_z, region
  output logic [((3*COORD_WIDTH+3+7)/8)*8-1:0]   m_axis_tdata
);

  localparam int CW   = COORD_WIDTH;
  localparam int WB   = cpt_pkg::WEIGHT_BITS;
  localparam int DIFW = CW + 1;
  localparam int PW   = 2 * DIFW;
  localparam int DW   = PW + 2;
  localparam int H    = (DW + 1) / 2;
  localparam int HH   = DW - H;
  localparam int PR   = 2 * DW;
  localparam int MW   = PR + 1;
  localparam int NW   = MW + 2;
  localparam int PPW  = DIFW + WB + 2;
  localparam int AW   = CW + WB + 3;
  localparam int RW   = AW - WB;
  localparam int OTW  = ((3*CW+3+7)/8)*8;

  localparam int ST_DIFF = 0;
  localparam int ST_PP   = 1;
  localparam int ST_DOT  = 2;
  localparam int ST_MPT  = 3;
  localparam int ST_MPR  = 4;
  localparam int ST_MIN  = 5;
  localparam int ST_SEL  = 6;
  localparam int ST_INI  = 7;
  localparam int ST_DIV0 = 8;
  localparam int ST_MUL  = ST_DIV0 + WB;
  localparam int ST_SUM  = ST_MUL + 1;
  localparam int ST_OUT  = ST_SUM + 1;
  localparam int NS      = ST_OUT + 1;

  typedef struct packed {
    logic [2:0][CW-1:0]   a, b, c;
    logic [2:0][DIFW-1:0] ab, ac, bc;
  } geo_t;

  typedef struct packed {
    logic [2*HH-1:0]   hh;
    logic [HH+H:0]     hl;
    logic [HH+H:0]     lh;
    logic [2*H-1:0]    ll;
  } mp_t;

  typedef struct packed {
    cpt_pkg::region_e     region;
    logic [2:0][CW-1:0]   base;
    logic [2:0][DIFW-1:0] dir1, dir2;
  } sel_t;

  typedef struct packed {
    sel_t          sel;
    logic          zero1, one1, zero2, one2;
    logic [NW-1:0] den, rem1, rem2;
    logic [WB-1:0] q1, q2;
  } div_t;

  typedef struct packed {
    cpt_pkg::region_e    region;
    logic [2:0][CW-1:0]  base;
    logic [2:0][PPW-1:0] p1, p2;
  } mul_t;

  typedef struct packed {
    cpt_pkg::region_e   region;
    logic [2:0][AW-1:0] acc;
  } sum_t;

  typedef struct packed {
    cpt_pkg::region_e   region;
    logic [2:0][CW-1:0] near;
  } out_t;

  function automatic mp_t split_mul(input logic signed [DW-1:0] x,
                                    input logic signed [DW-1:0] y);
    mp_t r;
    r.hh = $signed(x[DW-1:H]) * $signed(y[DW-1:H]);
    r.hl = $signed(x[DW-1:H]) * $signed({1'b0, y[H-1:0]});
    r.lh = $signed({1'b0, x[H-1:0]}) * $signed(y[DW-1:H]);
    r.ll = x[H-1:0] * y[H-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- handshake
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = ~v_q[NS-1] | m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = ~v_q[i] | en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NS-1];

  // ---------------------------------------------------------------- stage: differences
  logic signed [CW-1:0]   q_in [3];
  geo_t                   geo_d;
  logic signed [DIFW-1:0] qa_d [3], qb_d [3], qc_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_in[i]       = $signed(s_axis_tdata[i*CW +: CW]);
      geo_d.a[i]    = s_axis_tdata[(3+i)*CW +: CW];
      geo_d.b[i]    = s_axis_tdata[(6+i)*CW +: CW];
      geo_d.c[i]    = s_axis_tdata[(9+i)*CW +: CW];
      geo_d.ab[i]   = DIFW'($signed(geo_d.b[i])) - DIFW'($signed(geo_d.a[i]));
      geo_d.ac[i]   = DIFW'($signed(geo_d.c[i])) - DIFW'($signed(geo_d.a[i]));
      geo_d.bc[i]   = DIFW'($signed(geo_d.c[i])) - DIFW'($signed(geo_d.b[i]));
      qa_d[i]       = DIFW'(q_in[i]) - DIFW'($signed(geo_d.a[i]));
      qb_d[i]       = DIFW'(q_in[i]) - DIFW'($signed(geo_d.b[i]));
      qc_d[i]       = DIFW'(q_in[i]) - DIFW'($signed(geo_d.c[i]));
    end
  end

  geo_t                   geo_q [ST_MIN+1];
  logic signed [DIFW-1:0] qa_q [3], qb_q [3], qc_q [3];
  logic signed [PW-1:0]   pp_q [6][3];
  logic signed [DW-1:0]   dd_q [4][6];
  mp_t                    mp_q [6];
  logic signed [PR-1:0]   mpr_q [6];
  logic signed [MW-1:0]   va_q, vb_q, vc_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_DIFF]) begin
      geo_q[ST_DIFF] <= geo_d;
      qa_q <= qa_d;
      qb_q <= qb_d;
      qc_q <= qc_d;
    end
    for (int s = 1; s <= ST_MIN; s++) begin
      if (en[s]) geo_q[s] <= geo_q[s-1];
    end
    // dot product terms: d1..d6 = ab.qa, ac.qa, ab.qb, ac.qb, ab.qc, ac.qc
    if (en[ST_PP]) begin
      for (int i = 0; i < 3; i++) begin
        pp_q[0][i] <= $signed(geo_q[ST_DIFF].ab[i]) * qa_q[i];
        pp_q[1][i] <= $signed(geo_q[ST_DIFF].ac[i]) * qa_q[i];
        pp_q[2][i] <= $signed(geo_q[ST_DIFF].ab[i]) * qb_q[i];
        pp_q[3][i] <= $signed(geo_q[ST_DIFF].ac[i]) * qb_q[i];
        pp_q[4][i] <= $signed(geo_q[ST_DIFF].ab[i]) * qc_q[i];
        pp_q[5][i] <= $signed(geo_q[ST_DIFF].ac[i]) * qc_q[i];
      end
    end
    if (en[ST_DOT]) begin
      for (int k = 0; k < 6; k++) begin
        dd_q[0][k] <= DW'(pp_q[k][0]) + DW'(pp_q[k][1]) + DW'(pp_q[k][2]);
      end
    end
    for (int s = 1; s < 4; s++) begin
      if (en[ST_DOT+s]) dd_q[s] <= dd_q[s-1];
    end
    // minors: vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4
    if (en[ST_MPT]) begin
      mp_q[0] <= split_mul(dd_q[0][0], dd_q[0][3]);
      mp_q[1] <= split_mul(dd_q[0][2], dd_q[0][1]);
      mp_q[2] <= split_mul(dd_q[0][4], dd_q[0][1]);
      mp_q[3] <= split_mul(dd_q[0][0], dd_q[0][5]);
      mp_q[4] <= split_mul(dd_q[0][2], dd_q[0][5]);
      mp_q[5] <= split_mul(dd_q[0][4], dd_q[0][3]);
    end
    if (en[ST_MPR]) begin
      for (int k = 0; k < 6; k++) begin
        mpr_q[k] <= (PR'($signed(mp_q[k].hh)) <<< (2*H))
                  + (PR'($signed(mp_q[k].hl)) <<< H)
                  + (PR'($signed(mp_q[k].lh)) <<< H)
                  + $signed(PR'(mp_q[k].ll));
      end
    end
    if (en[ST_MIN]) begin
      vc_q <= MW'(mpr_q[0]) - MW'(mpr_q[1]);
      vb_q <= MW'(mpr_q[2]) - MW'(mpr_q[3]);
      va_q <= MW'(mpr_q[4]) - MW'(mpr_q[5]);
    end
  end

  // ---------------------------------------------------------------- stage: region select
  sel_t                 sel_d;
  logic signed [NW-1:0] num1_d, num2_d, den_d;

  always_comb begin
    logic signed [DW-1:0] d1, d2, d3, d4, d5, d6;
    logic signed [DW:0]   e1, e2;
    logic                 f_a, f_b, f_ab, f_c, f_ac, f_bc;
    geo_t                 g;
    d1 = dd_q[3][0];
    d2 = dd_q[3][1];
    d3 = dd_q[3][2];
    d4 = dd_q[3][3];
    d5 = dd_q[3][4];
    d6 = dd_q[3][5];
    g  = geo_q[ST_MIN];
    e1 = (DW+1)'(d4) - (DW+1)'(d3);
    e2 = (DW+1)'(d5) - (DW+1)'(d6);
    f_a  = (d1 <= 0) && (d2 <= 0);
    f_b  = (d3 >= 0) && (d4 <= d3);
    f_ab = (vc_q <= 0) && (d1 >= 0) && (d3 <= 0);
    f_c  = (d6 >= 0) && (d5 <= d6);
    f_ac = (vb_q <= 0) && (d2 >= 0) && (d6 <= 0);
    f_bc = (va_q <= 0) && (e1 >= 0) && (e2 >= 0);

    sel_d.base = g.a;
    sel_d.dir1 = g.ab;
    sel_d.dir2 = g.ac;
    num1_d     = '0;
    num2_d     = '0;
    den_d      = '0;
    if (f_a) begin
      sel_d.region = cpt_pkg::RGN_CORNER_A;
    end else if (f_b) begin
      sel_d.region = cpt_pkg::RGN_CORNER_B;
      sel_d.base   = g.b;
    end else if (f_ab) begin
      sel_d.region = cpt_pkg::RGN_EDGE_AB;
      num1_d       = NW'(d1);
      den_d        = NW'(d1) - NW'(d3);
    end else if (f_c) begin
      sel_d.region = cpt_pkg::RGN_CORNER_C;
      sel_d.base   = g.c;
    end else if (f_ac) begin
      sel_d.region = cpt_pkg::RGN_EDGE_AC;
      num2_d       = NW'(d2);
      den_d        = NW'(d2) - NW'(d6);
    end else if (f_bc) begin
      sel_d.region = cpt_pkg::RGN_EDGE_BC;
      sel_d.base   = g.b;
      sel_d.dir1   = g.bc;
      num1_d       = NW'(e1);
      den_d        = NW'(e1) + NW'(e2);
    end else begin
      sel_d.region = cpt_pkg::RGN_INTERIOR;
      num1_d       = NW'(vb_q);
      num2_d       = NW'(vc_q);
      den_d        = NW'(va_q) + NW'(vb_q) + NW'(vc_q);
    end
  end

  sel_t                 sel_q;
  logic signed [NW-1:0] num1_q, num2_q, den_q;
  div_t                 ini_q;
  div_t                 dv_q [WB];

  always_ff @(posedge clk_i) begin
    if (en[ST_SEL]) begin
      sel_q  <= sel_d;
      num1_q <= num1_d;
      num2_q <= num2_d;
      den_q  <= den_d;
    end
    // out-of-range weights clamp to 0 or 1; the quotient is used only when 0 < num < den
    if (en[ST_INI]) begin
      ini_q.sel   <= sel_q;
      ini_q.zero1 <= (den_q <= 0) || (num1_q <= 0);
      ini_q.one1  <= den_q <= num1_q;
      ini_q.zero2 <= (den_q <= 0) || (num2_q <= 0);
      ini_q.one2  <= den_q <= num2_q;
      ini_q.den   <= den_q;
      ini_q.rem1  <= num1_q;
      ini_q.rem2  <= num2_q;
      ini_q.q1    <= '0;
      ini_q.q2    <= '0;
    end
  end

  // ---------------------------------------------------------------- restoring divider, one bit a stage
  for (genvar k = 0; k < WB; k++) begin : g_div
    div_t div_in;
    div_t div_d;
    if (k == 0) begin : g_first
      assign div_in = ini_q;
    end else begin : g_next
      assign div_in = dv_q[k-1];
    end

    always_comb begin
      logic [NW:0] t1, t2;
      logic        ge1, ge2;
      div_d = div_in;
      t1    = {div_in.rem1, 1'b0};
      t2    = {div_in.rem2, 1'b0};
      ge1   = t1 >= {1'b0, div_in.den};
      ge2   = t2 >= {1'b0, div_in.den};
      div_d.rem1 = ge1 ? NW'(t1 - {1'b0, div_in.den}) : NW'(t1);
      div_d.rem2 = ge2 ? NW'(t2 - {1'b0, div_in.den}) : NW'(t2);
      div_d.q1   = {div_in.q1[WB-2:0], ge1};
      div_d.q2   = {div_in.q2[WB-2:0], ge2};
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_DIV0+k]) dv_q[k] <= div_d;
    end
  end

  // ---------------------------------------------------------------- blend and saturate
  logic [WB:0] w1, w2;
  div_t        dlast;

  assign dlast = dv_q[WB-1];
  assign w1 = dlast.zero1 ? '0 : (dlast.one1 ? (WB+1)'(1) << WB : {1'b0, dlast.q1});
  assign w2 = dlast.zero2 ? '0 : (dlast.one2 ? (WB+1)'(1) << WB : {1'b0, dlast.q2});

  mul_t mul_q;
  sum_t sum_q;
  out_t out_q;
  out_t out_d;

  always_comb begin
    logic [RW-1:0] rr;
    out_d.region = sum_q.region;
    for (int i = 0; i < 3; i++) begin
      rr = sum_q.acc[i][AW-1:WB];
      if ((&rr[RW-1:CW-1]) || !(|rr[RW-1:CW-1])) begin
        out_d.near[i] = rr[CW-1:0];
      end else begin
        out_d.near[i] = {rr[RW-1], {(CW-1){~rr[RW-1]}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      mul_q.region <= dlast.sel.region;
      mul_q.base   <= dlast.sel.base;
      for (int i = 0; i < 3; i++) begin
        mul_q.p1[i] <= $signed(dlast.sel.dir1[i]) * $signed({1'b0, w1});
        mul_q.p2[i] <= $signed(dlast.sel.dir2[i]) * $signed({1'b0, w2});
      end
    end
    if (en[ST_SUM]) begin
      sum_q.region <= mul_q.region;
      for (int i = 0; i < 3; i++) begin
        sum_q.acc[i] <= (AW'($signed(mul_q.base[i])) <<< WB)
                      + AW'($signed(mul_q.p1[i])) + AW'($signed(mul_q.p2[i]));
      end
    end
    if (en[ST_OUT]) out_q <= out_d;
  end

  assign m_axis_tdata = OTW'({out_q.region, out_q.near[2], out_q.near[1], out_q.near[0]});

endmodule

FILE: tb/tb_top.sv
// Testbench for closest_point_on_triangle_top: directed table plus random geometry, scoreboarded.
`timescale 1ns / 100ps

module tb_top;

  localparam int CW       = cpt_pkg::COORD_WIDTH;
  localparam int WBITS    = cpt_pkg::WEIGHT_BITS;
  localparam int IN_W     = ((12*CW+7)/8)*8;
  localparam int OUT_W    = ((3*CW+3+7)/8)*8;
  localparam int LATENCY  = WBITS + 11;
  localparam int N_RAND   = 1730;
  localparam int QUIET_AT = N_RAND - 200;
  localparam int WD_LIMIT = 4000;
  localparam int N_DIR    = 17;

  typedef logic signed [127:0] big_t;

  typedef struct {
    logic [CW-1:0]    x;
    logic [CW-1:0]    y;
    logic [CW-1:0]    z;
    cpt_pkg::region_e rgn;
  } near_t;

  typedef struct {
    int               c[12];
    bit               typed;
    int               ex;
    int               ey;
    int               ez;
    cpt_pkg::region_e rgn;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  near_t near_q[$];
  int    errors = 0;
  int    idle_cycles = 0;
  bit    quiet = 1'b0;
  bit    hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  closest_point_on_triangle_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic big_t tri_weight(big_t num, big_t den);
    if (den <= 0 || num <= 0) return 0;
    if (num >= den) return big_t'(1) <<< WBITS;
    return (num <<< WBITS) / den;
  endfunction

  function automatic big_t dot3(big_t u[3], big_t v[3]);
    return u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
  endfunction

  // Closest point and region for one request packed as on the bus.
  function automatic near_t closest_on_tri(logic [IN_W-1:0] td);
    big_t q[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], qa[3], qb[3], qc[3];
    big_t base[3], dir1[3], dir2[3];
    big_t d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, w1, w2, acc, r;
    big_t hi, lo;
    logic [CW-1:0] co[3];
    near_t res;
    hi = (big_t'(1) <<< (CW-1)) - 1;
    lo = -hi - 1;
    for (int i = 0; i < 3; i++) begin
      q[i]  = $signed(td[CW*i +: CW]);
      a[i]  = $signed(td[CW*(3+i) +: CW]);
      b[i]  = $signed(td[CW*(6+i) +: CW]);
      c[i]  = $signed(td[CW*(9+i) +: CW]);
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      bc[i] = c[i] - b[i];
      qa[i] = q[i] - a[i];
      qb[i] = q[i] - b[i];
      qc[i] = q[i] - c[i];
    end
    d1 = dot3(ab, qa); d2 = dot3(ac, qa);
    d3 = dot3(ab, qb); d4 = dot3(ac, qb);
    d5 = dot3(ab, qc); d6 = dot3(ac, qc);
    vc = d1*d4 - d3*d2;
    vb = d5*d2 - d1*d6;
    va = d3*d6 - d5*d4;
    base = a; dir1 = ab; dir2 = ac;
    w1 = 0; w2 = 0;
    if (d1 <= 0 && d2 <= 0) begin
      res.rgn = cpt_pkg::RGN_CORNER_A;
    end else if (d3 >= 0 && d4 <= d3) begin
      res.rgn = cpt_pkg::RGN_CORNER_B;
      base = b;
    end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      res.rgn = cpt_pkg::RGN_EDGE_AB;
      w1 = tri_weight(d1, d1 - d3);
    end else if (d6 >= 0 && d5 <= d6) begin
      res.rgn = cpt_pkg::RGN_CORNER_C;
      base = c;
    end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      res.rgn = cpt_pkg::RGN_EDGE_AC;
      w2 = tri_weight(d2, d2 - d6);
    end else begin
      e1 = d4 - d3;
      e2 = d5 - d6;
      if (va <= 0 && e1 >= 0 && e2 >= 0) begin
        res.rgn = cpt_pkg::RGN_EDGE_BC;
        base = b;
        dir1 = bc;
        w1 = tri_weight(e1, e1 + e2);
      end else begin
        res.rgn = cpt_pkg::RGN_INTERIOR;
        w1 = tri_weight(vb, va + vb + vc);
        w2 = tri_weight(vc, va + vb + vc);
      end
    end
    for (int i = 0; i < 3; i++) begin
      acc = (base[i] <<< WBITS) + dir1[i]*w1 + dir2[i]*w2;
      r = acc >>> WBITS;  // floor
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      co[i] = r[CW-1:0];
    end
    res.x = co[0]; res.y = co[1]; res.z = co[2];
    return res;
  endfunction

  // Offer one request and wait until it is taken.
  task automatic send_req(logic [IN_W-1:0] td, near_t exp_near);
    s_axis_tdata  <= td;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    near_q.push_back(exp_near);
  endtask

  task automatic idle_gap();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic logic [IN_W-1:0] rand_req();
    logic [IN_W-1:0] td;
    int mode, lim, ctr;
    td = '0;
    mode = $urandom_range(0, 9);
    lim = (mode < 6) ? 2048 : 256;
    ctr = $urandom_range(0, 16000) - 8000;
    for (int i = 0; i < 12; i++) begin
      if (mode < 3) td[CW*i +: CW] = CW'($urandom);
      else td[CW*i +: CW] = CW'(ctr + $urandom_range(0, 2*lim) - lim);
    end
    if (mode == 8) td[CW*6 +: 3*CW] = td[CW*3 +: 3*CW];       // B on A
    if (mode == 9) td[0 +: 3*CW] = td[CW*3*$urandom_range(1, 3) +: 3*CW];  // Q on a corner
    return td;
  endfunction

  row_t dir_rows [N_DIR] = '{
    '{'{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    '{'{100,200,300, 100,200,300, 900,-40,7, -500,60,12}, 1, 100, 200, 300,
      cpt_pkg::RGN_CORNER_A},
    '{'{900,-40,7, 100,200,300, 900,-40,7, -500,60,12}, 1, 900, -40, 7,
      cpt_pkg::RGN_CORNER_B},
    '{'{-32768,-32768,-32768, 32767,32767,32767, 32767,32767,32767, 32767,32767,32767},
      1, 32767, 32767, 32767, cpt_pkg::RGN_CORNER_A},
    '{'{32767,32767,32767, -32768,-32768,-32768, 32767,-32768,32767, -32768,32767,32767},
      0, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    '{'{-32768,32767,-32768, 32767,-32768,32767, -32768,-32768,-32768, 32767,32767,-32768},
      0, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    '{'{64,64,100, 0,0,0, 256,0,0, 0,256,0}, 0, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    '{'{256,-256,0, 0,0,0, 512,0,0, 0,512,0}, 0, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    '{'{-256,256,0, 0,0,0, 512,0,0, 0,512,0}, 0, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    '{'{512,512,0, 0,0,0, 512,0,0, 0,512,0}, 0, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    '{'{0,1024,0, 0,0,0, 512,0,0, 0,512,0}, 0, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    '{'{1024,-300,0, 0,0,0, 512,0,0, 0,512,0}, 0, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    // zero edge denominator on AB (A equals B)
    '{'{128,100,0, 0,0,0, 0,0,0, 256,0,0}, 0, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    // collinear corners: degenerate triangle, resolved as edge AB
    '{'{100,300,-50, 0,0,0, 256,256,256, 512,512,512}, 0, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    '{'{3,77,-5, 10,10,10, 10,10,10, 10,10,10}, 0, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    '{'{1,1,1, -7,3,0, 300,-11,0, 17,299,0}, 0, 0, 0, 0, cpt_pkg::RGN_CORNER_A},
    '{'{-32768,0,32767, 32767,0,-32768, -32768,32767,0, 0,-32768,32767}, 0, 0, 0, 0,
      cpt_pkg::RGN_CORNER_A}
  };

  // Stimulus
  initial begin
    logic [IN_W-1:0] td;
    near_t exp_near;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[r]) begin
      for (int i = 0; i < 12; i++) td[CW*i +: CW] = CW'(dir_rows[r].c[i]);
      if (dir_rows[r].typed) begin
        exp_near.x   = CW'(dir_rows[r].ex);
        exp_near.y   = CW'(dir_rows[r].ey);
        exp_near.z   = CW'(dir_rows[r].ez);
        exp_near.rgn = dir_rows[r].rgn;
      end else begin
        exp_near = closest_on_tri(td);
      end
      send_req(td, exp_near);
      idle_gap();
    end
    for (int n = 0; n < N_RAND; n++) begin
      if (n == 300) hold_req <= 1'b1;  // receiver holds off, input keeps coming
      if (n == 900) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (near_q.size() != 0) @(posedge clk_i);
      end
      if (n == QUIET_AT) quiet <= 1'b1;
      td = rand_req();
      send_req(td, closest_on_tri(td));
      idle_gap();
    end
    s_axis_tvalid <= 1'b0;
    while (near_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (m_axis_tvalid) begin
      $error("result left with no request outstanding");
    end
    if (errors == 0 && !m_axis_tvalid) begin
      $display("** closest_point_on_triangle_top: PASSED **");
    end else begin
      $display("** closest_point_on_triangle_top: FAILED **");
    end
    $finish;
  end

  // Result side: check, then pick next tready
  initial begin
    near_t exp_near;
    int hold_cnt, stall_cnt;
    bit hold_done;
    hold_cnt = 0;
    stall_cnt = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (near_q.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          exp_near = near_q.pop_front();
          if (m_axis_tdata[0 +: CW] !== exp_near.x) begin
            $error("near_x exp %0d got %0d", $signed(exp_near.x),
                   $signed(m_axis_tdata[0 +: CW]));
            errors++;
          end
          if (m_axis_tdata[CW +: CW] !== exp_near.y) begin
            $error("near_y exp %0d got %0d", $signed(exp_near.y),
                   $signed(m_axis_tdata[CW +: CW]));
            errors++;
          end
          if (m_axis_tdata[2*CW +: CW] !== exp_near.z) begin
            $error("near_z exp %0d got %0d", $signed(exp_near.z),
                   $signed(m_axis_tdata[2*CW +: CW]));
            errors++;
          end
          if (m_axis_tdata[3*CW +: 3] !== exp_near.rgn) begin
            $error("region exp %0d got %0d", exp_near.rgn, m_axis_tdata[3*CW +: 3]);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt = 300;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_cnt = $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("** closest_point_on_triangle_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: closest_point_on_triangle_top.f
src/cpt_pkg.sv
src/closest_point_on_triangle_top.sv
tb/tb_top.sv
